// ===== design/scanline_color_blob_finder_macros.svh =====
// ----------------------------------------------------------------------------
// Scan-line colour blob finder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef SCANLINE_COLOR_BLOB_FINDER_MACROS_SVH
`define SCANLINE_COLOR_BLOB_FINDER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SBF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbf assertion failed");
`define SBF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbf assertion failed");
`else
`define SBF_ASSERT_SAME(lbl, ante, cons)
`define SBF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/sbf_pkg.sv =====
// ----------------------------------------------------------------------------
// Scan-line colour blob finder package
// Shared types, register indexes, reset values and arctangent constants.
// ----------------------------------------------------------------------------
package sbf_pkg;

  localparam int DEF_MAX_SCAN_WIDTH    = 1024;
  localparam int DEF_FILTER_COLORS     = 4;
  localparam int DEF_ANGLE_TABLE_DEPTH = 1024;
  localparam int CORDIC_STEPS          = 24;

  localparam logic [10:0] RST_LINE_WIDTH        = 11'd80;
  localparam logic [10:0] RST_IMAGE_HEIGHT      = 11'd60;
  localparam logic [15:0] RST_PIXELS_PER_RADIAN = 16'd14668;

  typedef enum logic [2:0] {
    REG_LINE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_PIXELS_PER_RADIAN,
    REG_FILTER_COUNT,
    REG_FILTER_COLOR_A,
    REG_FILTER_COLOR_B,
    REG_FILTER_COLOR_C,
    REG_FILTER_COLOR_D
  } cfg_reg_t;

  typedef struct packed {
    logic        blob_valid;
    logic [23:0] blob_color;
    logic [9:0]  blob_left;
    logic [9:0]  blob_right;
    logic        scan_done;
  } job_t;

  typedef struct packed {
    logic        blob_valid;
    logic [23:0] blob_color;
    logic [9:0]  blob_left;
    logic [9:0]  blob_right;
    logic [10:0] blob_top;
    logic [10:0] blob_bottom;
    logic [15:0] blob_range;
    logic        scan_done;
  } res_t;

  function automatic logic [31:0] cordic_angle(input logic [4:0] j);
    case (j)
      5'd0:    cordic_angle = 32'h3243F6A8;
      5'd1:    cordic_angle = 32'h1DAC6705;
      5'd2:    cordic_angle = 32'h0FADBAFC;
      5'd3:    cordic_angle = 32'h07F56EA6;
      5'd4:    cordic_angle = 32'h03FEAB76;
      5'd5:    cordic_angle = 32'h01FFD55B;
      5'd6:    cordic_angle = 32'h00FFFAAA;
      5'd7:    cordic_angle = 32'h007FFF55;
      5'd8:    cordic_angle = 32'h003FFFEA;
      5'd9:    cordic_angle = 32'h001FFFFD;
      5'd10:   cordic_angle = 32'h000FFFFF;
      5'd11:   cordic_angle = 32'h0007FFFF;
      5'd12:   cordic_angle = 32'h0003FFFF;
      5'd13:   cordic_angle = 32'h0001FFFF;
      5'd14:   cordic_angle = 32'h0000FFFF;
      5'd15:   cordic_angle = 32'h00007FFF;
      5'd16:   cordic_angle = 32'h00003FFF;
      5'd17:   cordic_angle = 32'h00001FFF;
      5'd18:   cordic_angle = 32'h00000FFF;
      5'd19:   cordic_angle = 32'h000007FF;
      5'd20:   cordic_angle = 32'h000003FF;
      5'd21:   cordic_angle = 32'h000001FF;
      5'd22:   cordic_angle = 32'h000000FF;
      5'd23:   cordic_angle = 32'h0000007F;
      default: cordic_angle = 32'h00000000;
    endcase
  endfunction

endpackage

// ===== design/sbf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sbf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/sbf_fifo.sv =====
// ----------------------------------------------------------------------------
// Scan-line colour blob finder small queue
// A shallow register queue that decouples the stages on either side.
// ----------------------------------------------------------------------------
module sbf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        slots[wr_ptr] <= din;
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/sbf_front.sv =====
// ----------------------------------------------------------------------------
// Scan-line colour blob finder front end
// Tracks runs of equal-colour hits, applies the colour filter and issues
// one job for each sample that closes a kept blob or ends the scan.
// ----------------------------------------------------------------------------
module sbf_front #(
  parameter int MAX_SCAN_WIDTH = sbf_pkg::DEF_MAX_SCAN_WIDTH,
  parameter int FILTER_COLORS  = sbf_pkg::DEF_FILTER_COLORS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    take,
  input  logic                                    hit,
  input  logic [23:0]                             sample_color,
  input  logic [15:0]                             sample_range,
  input  logic                                    scan_end,
  input  logic [10:0]                             line_width,
  input  logic [2:0]                              filter_count,
  input  logic [FILTER_COLORS-1:0][23:0]          filter_colors,
  output logic                                    job_push,
  output sbf_pkg::job_t                           job,
  output logic [16+$clog2(MAX_SCAN_WIDTH+1)-1:0]  job_sum,
  output logic [$clog2(MAX_SCAN_WIDTH+1)-1:0]     job_len
);

  localparam int CW = $clog2(MAX_SCAN_WIDTH);
  localparam int LW = $clog2(MAX_SCAN_WIDTH + 1);
  localparam int SW = 16 + LW;

  logic          run_active;
  logic [23:0]   run_color;
  logic [CW-1:0] run_start_column;
  logic [SW-1:0] range_sum;
  logic [LW-1:0] run_length;
  logic [CW-1:0] column_index;

  logic          same;
  logic [SW-1:0] base_sum;
  logic [LW-1:0] base_len;
  logic [SW-1:0] add_sum;
  logic [LW-1:0] add_len;
  logic [CW-1:0] prev_col;
  logic [CW-1:0] last_col;
  logic          close;
  logic          use_new;
  logic [23:0]   cl_color;
  logic [CW-1:0] cl_start;
  logic [2:0]    n_used;
  logic          keep;
  logic          kept;

  always_comb begin
    same     = hit && (sample_color == run_color);
    base_sum = run_active ? range_sum : '0;
    base_len = run_active ? run_length : '0;
    if (base_len < LW'(MAX_SCAN_WIDTH)) begin
      add_sum = base_sum + SW'(sample_range);
      add_len = base_len + 1'b1;
    end else begin
      add_sum = base_sum;
      add_len = base_len;
    end
    prev_col = (column_index == '0) ? CW'(MAX_SCAN_WIDTH - 1) : column_index - 1'b1;
    close    = 1'b0;
    use_new  = 1'b0;
    last_col = column_index;
    if (run_active) begin
      if (same) begin
        close   = scan_end;
        use_new = 1'b1;
      end else begin
        close    = 1'b1;
        last_col = prev_col;
      end
    end else if (hit) begin
      close   = scan_end;
      use_new = 1'b1;
    end
    cl_color = run_active ? run_color : sample_color;
    cl_start = run_active ? run_start_column : column_index;
    n_used   = (filter_count > 3'(FILTER_COLORS)) ? 3'(FILTER_COLORS) : filter_count;
    keep     = (n_used == '0);
    for (int c = 0; c < FILTER_COLORS; c++) begin
      if ((3'(c) < n_used) && (filter_colors[c] == cl_color)) begin
        keep = 1'b1;
      end
    end
    kept = close && keep;
  end

  assign job_push        = take && (kept || scan_end);
  assign job.blob_valid  = kept;
  assign job.blob_color  = kept ? cl_color : '0;
  assign job.blob_left   = kept ? 10'(line_width[9:0] - 10'(last_col) - 10'd1) : '0;
  assign job.blob_right  = kept ? 10'(line_width[9:0] - 10'(cl_start) - 10'd1) : '0;
  assign job.scan_done   = scan_end;
  assign job_sum         = use_new ? add_sum : range_sum;
  assign job_len         = use_new ? add_len : run_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_active       <= 1'b0;
      run_color        <= '0;
      run_start_column <= '0;
      range_sum        <= '0;
      run_length       <= '0;
      column_index     <= '0;
    end else if (take) begin
      if (close || scan_end) begin
        run_active       <= 1'b0;
        run_color        <= '0;
        run_start_column <= '0;
        range_sum        <= '0;
        run_length       <= '0;
      end else if (run_active) begin
        range_sum  <= add_sum;
        run_length <= add_len;
      end else if (hit) begin
        run_active       <= 1'b1;
        run_color        <= sample_color;
        run_start_column <= column_index;
        range_sum        <= add_sum;
        run_length       <= add_len;
      end
      if (scan_end || (column_index == CW'(MAX_SCAN_WIDTH - 1))) begin
        column_index <= '0;
      end else begin
        column_index <= column_index + 1'b1;
      end
    end
  end

endmodule

// ===== design/sbf_angle_fill.sv =====
// ----------------------------------------------------------------------------
// Scan-line colour blob finder angle table fill
// After reset, computes atan2(0.3, i/16) for every table entry with an
// iterative vectoring CORDIC, one step per cycle, and writes it to the RAM.
// ----------------------------------------------------------------------------
module sbf_angle_fill #(
  parameter int ANGLE_TABLE_DEPTH = sbf_pkg::DEF_ANGLE_TABLE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  output logic                                 wr_en,
  output logic [$clog2(ANGLE_TABLE_DEPTH)-1:0] wr_addr,
  output logic [15:0]                          wr_data,
  output logic                                 done
);

  localparam int IW = $clog2(ANGLE_TABLE_DEPTH);
  localparam int XW = 38;
  localparam int ZW = 34;

  typedef enum logic [1:0] {F_INIT, F_STEP, F_WRITE, F_DONE} fill_state_t;

  fill_state_t           state;
  logic [IW-1:0]         idx;
  logic [4:0]            j;
  logic signed [XW-1:0]  x;
  logic signed [XW-1:0]  y;
  logic signed [ZW-1:0]  z;
  logic signed [XW-1:0]  xs;
  logic signed [XW-1:0]  ys;
  logic signed [ZW-1:0]  ang;
  logic [ZW-1:0]         zc;
  logic [ZW-1:0]         zr;

  function automatic logic signed [XW-1:0] tshr(input logic signed [XW-1:0] v,
                                                input logic [4:0] s);
    logic signed [XW-1:0] nv;
    nv   = -v;
    tshr = v[XW-1] ? -(nv >>> s) : (v >>> s);
  endfunction

  always_comb begin
    xs  = tshr(x, j);
    ys  = tshr(y, j);
    ang = $signed(ZW'(sbf_pkg::cordic_angle(j)));
    zc  = z[ZW-1] ? '0 : z;
    zr  = (zc + ZW'(1 << 14)) >> 15;
  end

  assign wr_en   = (state == F_WRITE);
  assign wr_addr = idx;
  assign wr_data = (zr > ZW'(65535)) ? 16'hFFFF : 16'(zr);
  assign done    = (state == F_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_INIT;
      idx   <= '0;
      j     <= '0;
    end else begin
      case (state)
        F_INIT: begin
          x     <= ($signed(XW'(idx)) * $signed(XW'(5))) <<< 20;
          y     <= $signed(XW'(24)) <<< 20;
          z     <= '0;
          j     <= '0;
          state <= F_STEP;
        end
        F_STEP: begin
          if (!y[XW-1]) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + ang;
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - ang;
          end
          j <= j + 1'b1;
          if (j == 5'(sbf_pkg::CORDIC_STEPS - 1)) begin
            state <= F_WRITE;
          end
        end
        F_WRITE: begin
          if (idx == IW'(ANGLE_TABLE_DEPTH - 1)) begin
            state <= F_DONE;
          end else begin
            idx   <= idx + 1'b1;
            state <= F_INIT;
          end
        end
        F_DONE: begin
          state <= F_DONE;
        end
        default: begin
          state <= F_INIT;
        end
      endcase
    end
  end

endmodule

// ===== design/sbf_back.sv =====
// ----------------------------------------------------------------------------
// Scan-line colour blob finder back end
// Divides the range sum by the run length one quotient bit per cycle, looks
// up the half angle, scales it to rows and clamps the top and bottom rows.
// ----------------------------------------------------------------------------
`include "scanline_color_blob_finder_macros.svh"

module sbf_back #(
  parameter int MAX_SCAN_WIDTH    = sbf_pkg::DEF_MAX_SCAN_WIDTH,
  parameter int ANGLE_TABLE_DEPTH = sbf_pkg::DEF_ANGLE_TABLE_DEPTH
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    fill_done,
  input  logic                                    job_empty,
  input  sbf_pkg::job_t                           job,
  input  logic [16+$clog2(MAX_SCAN_WIDTH+1)-1:0]  job_sum,
  input  logic [$clog2(MAX_SCAN_WIDTH+1)-1:0]     job_len,
  output logic                                    job_pop,
  output logic [$clog2(ANGLE_TABLE_DEPTH)-1:0]    rd_addr,
  input  logic [15:0]                             rd_data,
  input  logic [10:0]                             image_height,
  input  logic [15:0]                             pixels_per_radian,
  input  logic                                    res_full,
  output logic                                    res_push,
  output sbf_pkg::res_t                           res
);

  localparam int LW = $clog2(MAX_SCAN_WIDTH + 1);
  localparam int IW = $clog2(ANGLE_TABLE_DEPTH);
  localparam logic [12:0] IdxMax = 13'(ANGLE_TABLE_DEPTH - 1);

  typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_LOOK, ST_MUL, ST_FIN} back_state_t;

  back_state_t   state;
  sbf_pkg::job_t cur;
  logic [LW-1:0] rem;
  logic [LW-1:0] len;
  logic [15:0]   sum_lo;
  logic [15:0]   quo;
  logic [3:0]    cnt;
  logic [31:0]   prod;

  logic [LW:0]   trial;
  logic          fits;
  logic [8:0]    k;
  logic [10:0]   half;
  logic [11:0]   low_row;
  logic [11:0]   high_row;

  always_comb begin
    trial    = {rem, sum_lo[15]};
    fits     = (trial >= {1'b0, len});
    k        = prod[31:23];
    half     = {1'b0, image_height[10:1]};
    low_row  = (half >= 11'(k)) ? 12'(half - 11'(k)) : '0;
    high_row = 12'(half) + 12'(k);
    if (high_row > 12'(image_height)) begin
      high_row = 12'(image_height);
    end
  end

  assign rd_addr  = ({1'b0, quo[15:4]} > IdxMax) ? IW'(ANGLE_TABLE_DEPTH - 1) : IW'(quo[15:4]);
  assign job_pop  = (state == ST_IDLE) && fill_done && !job_empty;
  assign res_push = (state == ST_FIN) && !res_full;

  assign res.blob_valid  = cur.blob_valid;
  assign res.blob_color  = cur.blob_color;
  assign res.blob_left   = cur.blob_left;
  assign res.blob_right  = cur.blob_right;
  assign res.blob_top    = cur.blob_valid ? low_row[10:0] : '0;
  assign res.blob_bottom = cur.blob_valid ? high_row[10:0] : '0;
  assign res.blob_range  = cur.blob_valid ? quo : '0;
  assign res.scan_done   = cur.scan_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (job_pop) begin
            cur    <= job;
            rem    <= job_sum[16 +: LW];
            sum_lo <= job_sum[15:0];
            len    <= job_len;
            quo    <= '0;
            cnt    <= '0;
            state  <= job.blob_valid ? ST_DIV : ST_FIN;
          end
        end
        ST_DIV: begin
          rem    <= fits ? LW'(trial - {1'b0, len}) : LW'(trial);
          quo    <= {quo[14:0], fits};
          sum_lo <= {sum_lo[14:0], 1'b0};
          cnt    <= cnt + 1'b1;
          if (cnt == 4'd15) begin
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          prod  <= rd_data * pixels_per_radian;
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!res_full) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `SBF_ASSERT_SAME(a_busy_after_fill, state != ST_IDLE, fill_done)
  `SBF_ASSERT_SAME(a_push_has_room, res_push, !res_full)
  `SBF_ASSERT_NEXT(a_blob_starts_div, job_pop && job.blob_valid, state == ST_DIV)
  `SBF_ASSERT_NEXT(a_div_ends_look, state == ST_DIV && cnt == 4'd15, state == ST_LOOK)

endmodule

// ===== design/scanline_color_blob_finder.sv =====
// ----------------------------------------------------------------------------
// Scan-line colour blob finder
// Groups runs of equal-colour hits of a scan line into blobs and reports
// their columns, mean range and the rows that they span.
// ----------------------------------------------------------------------------
// Samples enter through push/full; a transaction takes place when push is
// high and full is low. Results leave through empty/pop; the oldest result
// sits on the blob_* and scan_done ports while empty is low and is taken
// when pop is high. Registers are written through cfg_valid/cfg_ready with
// cfg_index and cfg_data; the user must write them only while the block is
// idle, which the block itself does not enforce. cfg_ready is always high.
// The front end takes one sample per cycle once the angle table is filled
// and while its job queue has room. In the back end a kept blob is loaded,
// takes 16 divide steps, one table read and one multiply, and hands over its
// result; an end-of-scan sample without a blob is only loaded and handed on.
// The back end, with its bit-serial divider, sets the sustained blob rate.
// After reset an iterative CORDIC fills the arctangent table entry by entry;
// full stays high until then. If the receiver stalls, results wait in a
// two-deep output queue and then in a two-deep job queue, then full rises.
// ----------------------------------------------------------------------------
module scanline_color_blob_finder #(
  parameter int MAX_SCAN_WIDTH    = sbf_pkg::DEF_MAX_SCAN_WIDTH,
  parameter int FILTER_COLORS     = sbf_pkg::DEF_FILTER_COLORS,
  parameter int ANGLE_TABLE_DEPTH = sbf_pkg::DEF_ANGLE_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        hit,
  input  logic [23:0] sample_color,
  input  logic [15:0] sample_range,
  input  logic        scan_end,
  output logic        empty,
  input  logic        pop,
  output logic        blob_valid,
  output logic [23:0] blob_color,
  output logic [9:0]  blob_left,
  output logic [9:0]  blob_right,
  output logic [10:0] blob_top,
  output logic [10:0] blob_bottom,
  output logic [15:0] blob_range,
  output logic        scan_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int LW = $clog2(MAX_SCAN_WIDTH + 1);
  localparam int SW = 16 + LW;
  localparam int IW = $clog2(ANGLE_TABLE_DEPTH);
  localparam int JW = $bits(sbf_pkg::job_t) + SW + LW;
  localparam int RW = $bits(sbf_pkg::res_t);

  logic [10:0]                    line_width;
  logic [10:0]                    image_height;
  logic [15:0]                    pixels_per_radian;
  logic [2:0]                     filter_count;
  logic [FILTER_COLORS-1:0][23:0] filter_colors;

  logic          take;
  logic          job_push;
  sbf_pkg::job_t job_in;
  logic [SW-1:0] sum_in;
  logic [LW-1:0] len_in;
  logic          job_full;
  logic          job_empty;
  logic          job_pop;
  logic [JW-1:0] job_head;
  sbf_pkg::job_t job_out;
  logic [SW-1:0] sum_out;
  logic [LW-1:0] len_out;

  logic          fill_wr_en;
  logic [IW-1:0] fill_wr_addr;
  logic [15:0]   fill_wr_data;
  logic          fill_done;
  logic [IW-1:0] rd_addr;
  logic [15:0]   rd_data;

  logic          res_full;
  logic          res_push;
  sbf_pkg::res_t res_in;
  sbf_pkg::res_t res_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width        <= sbf_pkg::RST_LINE_WIDTH;
      image_height      <= sbf_pkg::RST_IMAGE_HEIGHT;
      pixels_per_radian <= sbf_pkg::RST_PIXELS_PER_RADIAN;
      filter_count      <= '0;
      filter_colors     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sbf_pkg::REG_LINE_WIDTH:        line_width        <= cfg_data[10:0];
        sbf_pkg::REG_IMAGE_HEIGHT:      image_height      <= cfg_data[10:0];
        sbf_pkg::REG_PIXELS_PER_RADIAN: pixels_per_radian <= cfg_data[15:0];
        sbf_pkg::REG_FILTER_COUNT:      filter_count      <= cfg_data[2:0];
        default: begin
          for (int c = 0; c < FILTER_COLORS; c++) begin
            if (cfg_index == 3'(sbf_pkg::REG_FILTER_COLOR_A) + 3'(c)) begin
              filter_colors[c] <= cfg_data;
            end
          end
        end
      endcase
    end
  end

  assign full = !fill_done || job_full;
  assign take = push && !full;

  sbf_front #(
    .MAX_SCAN_WIDTH(MAX_SCAN_WIDTH),
    .FILTER_COLORS (FILTER_COLORS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .hit          (hit),
    .sample_color (sample_color),
    .sample_range (sample_range),
    .scan_end     (scan_end),
    .line_width   (line_width),
    .filter_count (filter_count),
    .filter_colors(filter_colors),
    .job_push     (job_push),
    .job          (job_in),
    .job_sum      (sum_in),
    .job_len      (len_in)
  );

  sbf_fifo #(
    .WIDTH(JW),
    .DEPTH(2)
  ) u_job_q (
    .clk  (clk),
    .rst  (rst),
    .push (job_push),
    .din  ({job_in, sum_in, len_in}),
    .full (job_full),
    .pop  (job_pop),
    .dout (job_head),
    .empty(job_empty)
  );

  assign {job_out, sum_out, len_out} = job_head;

  sbf_angle_fill #(
    .ANGLE_TABLE_DEPTH(ANGLE_TABLE_DEPTH)
  ) u_fill (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (fill_wr_en),
    .wr_addr(fill_wr_addr),
    .wr_data(fill_wr_data),
    .done   (fill_done)
  );

  sbf_ram #(
    .WIDTH(16),
    .DEPTH(ANGLE_TABLE_DEPTH)
  ) u_angle_ram (
    .clk    (clk),
    .wr_en  (fill_wr_en),
    .wr_addr(fill_wr_addr),
    .wr_data(fill_wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  sbf_back #(
    .MAX_SCAN_WIDTH   (MAX_SCAN_WIDTH),
    .ANGLE_TABLE_DEPTH(ANGLE_TABLE_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .fill_done        (fill_done),
    .job_empty        (job_empty),
    .job              (job_out),
    .job_sum          (sum_out),
    .job_len          (len_out),
    .job_pop          (job_pop),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .image_height     (image_height),
    .pixels_per_radian(pixels_per_radian),
    .res_full         (res_full),
    .res_push         (res_push),
    .res              (res_in)
  );

  sbf_fifo #(
    .WIDTH(RW),
    .DEPTH(2)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res_in),
    .full (res_full),
    .pop  (pop),
    .dout (res_out),
    .empty(empty)
  );

  assign blob_valid  = res_out.blob_valid;
  assign blob_color  = res_out.blob_color;
  assign blob_left   = res_out.blob_left;
  assign blob_right  = res_out.blob_right;
  assign blob_top    = res_out.blob_top;
  assign blob_bottom = res_out.blob_bottom;
  assign blob_range  = res_out.blob_range;
  assign scan_done   = res_out.scan_done;

endmodule

// ===== sim/scanline_color_blob_finder_test.sv =====
// ----------------------------------------------------------------------------
// Scan-line colour blob finder testbench
// Drives scan-line samples through the push/full side under random gaps,
// pops results under random stalls and compares every result field by field
// with a predictor of the blob finder kept in step with each transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scanline_color_blob_finder_test;

  localparam int SCAN_LIMIT   = 1024;
  localparam int TABLE_DEPTH  = 1024;
  localparam int SETTLE       = 64;
  localparam int STALL_LIMIT  = 100000;
  localparam int LONG_HOLD    = 300;

  typedef struct {
    bit            hit;
    bit [23:0]     color;
    bit [15:0]     range;
    bit            last;
    bit            typed;
    sbf_pkg::res_t want;
  } sample_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        hit = 1'b0;
  logic [23:0] sample_color = '0;
  logic [15:0] sample_range = '0;
  logic        scan_end = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        blob_valid;
  logic [23:0] blob_color;
  logic [9:0]  blob_left;
  logic [9:0]  blob_right;
  logic [10:0] blob_top;
  logic [10:0] blob_bottom;
  logic [15:0] blob_range;
  logic        scan_done;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  scanline_color_blob_finder DUT (.*);

  always #10 clk = ~clk;

  // Predictor state.
  logic [15:0] half_angle[TABLE_DEPTH];
  int unsigned width_cfg, height_cfg, ppr_cfg, fcount_cfg;
  logic [23:0] fcolor_cfg[4];
  bit          run_on;
  logic [23:0] run_colour;
  int unsigned run_first, run_len, column;
  longint unsigned run_sum;

  sbf_pkg::res_t pending_results[$];
  sample_row_t   directed[$];
  logic [23:0] palette[7] = '{24'hFFFFFF, 24'h000000, 24'h123456, 24'hFF0000,
                              24'h00FF00, 24'h0000FF, 24'hA5A5A5};

  int errors = 0;
  int items_sent = 0;
  int blobs_seen = 0;
  int scans_seen = 0;
  int idle_cycles = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rx_gap = 0;
  bit rx_burst = 1'b0;
  bit tx_burst = 1'b0;
  bit gen_in_run = 1'b0;
  logic [23:0] gen_colour = '0;

  const longint angle_q30[24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

  function automatic logic [15:0] elevation_angle(int i);
    longint x, y, z, nx, d;
    x = longint'(i) * 5 * (longint'(1) << 20);
    y = 24 * (longint'(1) << 20);
    z = 0;
    for (int j = 0; j < 24; j++) begin
      d = longint'(1) << j;
      if (y >= 0) begin
        nx = x + y / d;
        y = y - x / d;
        z += angle_q30[j];
      end else begin
        nx = x - y / d;
        y = y + x / d;
        z -= angle_q30[j];
      end
      x = nx;
    end
    if (z < 0) z = 0;
    z = (z + (longint'(1) << 14)) / (longint'(1) << 15);
    if (z > 65535) z = 65535;
    return z[15:0];
  endfunction

  function automatic bit colour_kept(logic [23:0] c);
    int n;
    n = (fcount_cfg > 4) ? 4 : fcount_cfg;
    if (n == 0) return 1'b1;
    for (int i = 0; i < n; i++)
      if (fcolor_cfg[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void clear_run();
    run_on = 1'b0;
    run_colour = '0;
    run_first = 0;
    run_sum = 0;
    run_len = 0;
  endfunction

  function automatic void add_range(logic [15:0] r);
    if (run_len < SCAN_LIMIT) begin
      run_sum += r;
      run_len++;
    end
  endfunction

  function automatic bit close_run(int unsigned last_col, ref sbf_pkg::res_t r);
    int unsigned mean, idx;
    longint k, top, bottom, half;
    bit keep;
    keep = colour_kept(run_colour);
    if (keep) begin
      mean = (run_len != 0) ? int'(run_sum / run_len) : 0;
      mean &= 32'hFFFF;
      idx = mean >> 4;
      if (idx > TABLE_DEPTH - 1) idx = TABLE_DEPTH - 1;
      k = (longint'(half_angle[idx]) * longint'(ppr_cfg)) >>> 23;
      half = height_cfg / 2;
      top = half - k;
      bottom = half + k;
      if (top < 0) top = 0;
      if (bottom > longint'(height_cfg)) bottom = height_cfg;
      r.blob_valid = 1'b1;
      r.blob_color = run_colour;
      r.blob_left = 10'(longint'(width_cfg) - last_col - 1);
      r.blob_right = 10'(longint'(width_cfg) - run_first - 1);
      r.blob_top = 11'(top);
      r.blob_bottom = 11'(bottom);
      r.blob_range = mean[15:0];
    end
    clear_run();
    return keep;
  endfunction

  // Advances the predictor by one sample; returns 1 when a result is due.
  function automatic bit predict_blob(sample_row_t s, ref sbf_pkg::res_t r);
    int unsigned col, prev;
    bit due;
    col = column;
    prev = (col == 0) ? SCAN_LIMIT - 1 : col - 1;
    due = 1'b0;
    r = '0;
    if (run_on) begin
      if (s.hit && s.color == run_colour) begin
        add_range(s.range);
        if (s.last) due = close_run(col, r);
      end else begin
        due = close_run(prev, r);
      end
    end else if (s.hit) begin
      run_on = 1'b1;
      run_colour = s.color;
      run_first = col;
      run_sum = 0;
      run_len = 0;
      add_range(s.range);
      if (s.last) due = close_run(col, r);
    end
    if (s.last) begin
      clear_run();
      column = 0;
      r.scan_done = 1'b1;
      return 1'b1;
    end
    column = (col + 1 >= SCAN_LIMIT) ? 0 : col + 1;
    return due;
  endfunction

  task automatic send_sample(sample_row_t s);
    sbf_pkg::res_t r;
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    hit <= s.hit;
    sample_color <= s.color;
    sample_range <= s.range;
    scan_end <= s.last;
    do @(posedge clk); while (full);
    items_sent++;
    if (predict_blob(s, r)) pending_results = {pending_results, (s.typed ? s.want : r)};
    if ($urandom_range(0, 49) == 0) tx_burst = ~tx_burst;
  endtask

  task automatic write_registers(logic [23:0] vals[8]);
    sbf_pkg::cfg_reg_t idx;
    idx = idx.first;
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx)
        sbf_pkg::REG_LINE_WIDTH:        width_cfg = vals[i][10:0];
        sbf_pkg::REG_IMAGE_HEIGHT:      height_cfg = vals[i][10:0];
        sbf_pkg::REG_PIXELS_PER_RADIAN: ppr_cfg = vals[i][15:0];
        sbf_pkg::REG_FILTER_COUNT:      fcount_cfg = vals[i][2:0];
        sbf_pkg::REG_FILTER_COLOR_A:    fcolor_cfg[0] = vals[i];
        sbf_pkg::REG_FILTER_COLOR_B:    fcolor_cfg[1] = vals[i];
        sbf_pkg::REG_FILTER_COLOR_C:    fcolor_cfg[2] = vals[i];
        sbf_pkg::REG_FILTER_COLOR_D:    fcolor_cfg[3] = vals[i];
        default: ;
      endcase
      idx = idx.next;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_quiet();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic sample_row_t random_sample();
    sample_row_t s;
    s.typed = 1'b0;
    s.want = '0;
    s.range = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 800));
    s.last = ($urandom_range(0, 39) == 0);
    s.color = 24'($urandom);
    if ($urandom_range(0, 99) < 8) begin
      s.hit = $urandom_range(0, 1);
      gen_in_run = 1'b0;
    end else if (gen_in_run && $urandom_range(0, 99) < 70) begin
      s.hit = 1'b1;
      s.color = gen_colour;
    end else if ($urandom_range(0, 99) < 60) begin
      gen_colour = palette[$urandom_range(0, 6)];
      gen_in_run = 1'b1;
      s.hit = 1'b1;
      s.color = gen_colour;
    end else begin
      s.hit = 1'b0;
      gen_in_run = 1'b0;
    end
    return s;
  endfunction

  function automatic sample_row_t row(bit h, logic [23:0] c, logic [15:0] r, bit e);
    sample_row_t s;
    s.hit = h;
    s.color = c;
    s.range = r;
    s.last = e;
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Result side: checks every transaction and stalls at random.
  always @(posedge clk) begin
    sbf_pkg::res_t w;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, actual valid %0b done %0b", $time,
                   blob_valid, scan_done);
        end else begin
          w = pending_results.pop_front();
          check_field("blob_valid", w.blob_valid, blob_valid);
          check_field("blob_color", w.blob_color, blob_color);
          check_field("blob_left", w.blob_left, blob_left);
          check_field("blob_right", w.blob_right, blob_right);
          check_field("blob_top", w.blob_top, blob_top);
          check_field("blob_bottom", w.blob_bottom, blob_bottom);
          check_field("blob_range", w.blob_range, blob_range);
          check_field("scan_done", w.scan_done, scan_done);
        end
        if (blob_valid) blobs_seen++;
        if (scan_done) scans_seen++;
        if ($urandom_range(0, 19) == 0) rx_burst = ~rx_burst;
        rx_gap = rx_burst ? 0 : $urandom_range(0, 16);
      end
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("scanline_color_blob_finder_test: FAIL");
      $finish;
    end
  end

  initial begin
    logic [23:0] vals[8];
    sample_row_t s;
    for (int i = 0; i < TABLE_DEPTH; i++) half_angle[i] = elevation_angle(i);
    width_cfg = sbf_pkg::RST_LINE_WIDTH;
    height_cfg = sbf_pkg::RST_IMAGE_HEIGHT;
    ppr_cfg = sbf_pkg::RST_PIXELS_PER_RADIAN;
    fcount_cfg = 0;
    fcolor_cfg = '{default: '0};
    clear_run();
    column = 0;

    // Directed samples under the reset settings.
    s = row(1'b0, 24'h0, 16'h0, 1'b1);
    s.typed = 1'b1;
    s.want.scan_done = 1'b1;
    directed = {directed, s};
    s = row(1'b1, 24'hFFFFFF, 16'h0, 1'b1);
    s.typed = 1'b1;
    s.want = '{1'b1, 24'hFFFFFF, 10'd79, 10'd79, 11'd0, 11'd60, 16'd0, 1'b1};
    directed = {directed, s};
    directed = {directed, row(1'b1, 24'h000000, 16'hFFFF, 1'b0)};
    directed = {directed, row(1'b1, 24'h000000, 16'hFFFF, 1'b0)};
    directed = {directed, row(1'b0, 24'hFFFFFF, 16'hFFFF, 1'b0)};
    directed = {directed, row(1'b1, 24'h800001, 16'h0100, 1'b0)};
    directed = {directed, row(1'b1, 24'h800000, 16'h0200, 1'b0)};
    directed = {directed, row(1'b1, 24'h800000, 16'h0300, 1'b0)};
    directed = {directed, row(1'b1, 24'h800000, 16'h0010, 1'b1)};
    directed = {directed, row(1'b1, 24'h00FF00, 16'h0040, 1'b0)};
    directed = {directed, row(1'b1, 24'h00FF00, 16'h0041, 1'b0)};
    directed = {directed, row(1'b0, 24'h00FF00, 16'h0000, 1'b1)};
    directed = {directed, row(1'b1, 24'h0000FF, 16'h3FF0, 1'b0)};
    directed = {directed, row(1'b1, 24'h0000FF, 16'h3FFF, 1'b1)};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_sample(directed[i]);

    for (int phase = 0; phase < 8; phase++) begin
      wait_quiet();
      case (phase)
        0: vals = '{24'd1, 24'd1, 24'd1, 24'd0, 24'h0, 24'h0, 24'h0, 24'h0};
        1: vals = '{24'd1024, 24'd1024, 24'd65535, 24'd4,
                    palette[0], palette[1], palette[2], palette[3]};
        2: vals = '{24'd2047, 24'd0, 24'd0, 24'd7,
                    palette[4], palette[5], palette[6], 24'($urandom)};
        default: begin
          vals[0] = $urandom_range(1, 1024);
          vals[1] = $urandom_range(1, 1024);
          vals[2] = $urandom_range(1, 65535);
          vals[3] = $urandom_range(0, 4);
          for (int i = 4; i < 8; i++)
            vals[i] = ($urandom_range(0, 4) == 0) ? 24'($urandom)
                                                   : palette[$urandom_range(0, 6)];
        end
      endcase
      if (phase > 0) write_registers(vals);
      if (phase == 3) hold_token++;
      if (phase == 1) begin
        // One run longer than the column range, closed by the end of scan.
        for (int i = 0; i < 1100; i++) begin
          s = row(1'b1, palette[2], 16'($urandom), i == 1099);
          send_sample(s);
        end
      end
      for (int i = 0; i < 60; i++) send_sample(random_sample());
    end

    wait_quiet();
    $display("Covered %0d samples giving %0d blobs and %0d scan ends", items_sent,
             blobs_seen, scans_seen);
    $display("over eight register settings, with a long result stall and filled queues.");
    if (errors == 0)
      $display("scanline_color_blob_finder_test: PASS");
    else
      $display("scanline_color_blob_finder_test: FAIL");
    $finish;
  end

endmodule
